/* rtl/core/pir_pkg.sv */
// Package for the privileged instruction rewriter.
// Holds the payload structs, opcode and magic-page constants and patch kind codes.
// No dependencies.
`default_nettype none

package pir_pkg;

  // Default arena size in bytes
  localparam int ARENA_BYTES_DEF = 1048576;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STUB_ARENA_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSR_STUB_WORDS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGREG_STUB_WORDS = 2'd2;
  localparam int CFG_DATA_W = 32;
  localparam int STUB_WORDS_W = 11;
  localparam logic [STUB_WORDS_W-1:0] STUB_WORDS_RST = 11'd16;

  // Patch kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_LOAD  = 3'd1;
  localparam logic [2:0] KIND_STORE = 3'd2;
  localparam logic [2:0] KIND_NOP   = 3'd3;
  localparam logic [2:0] KIND_MSR   = 3'd4;
  localparam logic [2:0] KIND_SEG   = 3'd5;
  localparam logic [2:0] KIND_NOSPC = 3'd6;
  localparam logic [2:0] KIND_RANGE = 3'd7;

  // Opcodes and fields
  localparam logic [31:0] OP_LWZ     = 32'h8000_0000;
  localparam logic [31:0] OP_STW     = 32'h9000_0000;
  localparam logic [31:0] OP_NOP     = 32'h6000_0000;
  localparam logic [31:0] OP_B       = 32'h4800_0000;
  localparam logic [31:0] B_MASK     = 32'h03ff_ffff;
  localparam logic [31:0] FLD_RT     = 32'h03e0_0000;
  localparam logic [31:0] FLD_RB     = 32'h0000_f800;
  localparam logic [31:0] OP_MFMSR   = 32'h7c00_00a6;
  localparam logic [31:0] OP_MTMSR   = 32'h7c00_0124;
  localparam logic [31:0] OP_MTMSRD0 = 32'h7c00_0164;
  localparam logic [31:0] OP_MTMSRD1 = 32'h7c01_0164;
  localparam logic [31:0] OP_MTSRIN  = 32'h7c00_01e4;
  localparam logic [31:0] OP_TLBSYNC = 32'h7c00_046c;
  localparam logic [31:0] OP_DCBA    = 32'h7c00_05ec;

  // mfspr / mtspr encodings with RT cleared
  localparam logic [31:0] MF_SPRG0 = 32'h7c10_42a6;
  localparam logic [31:0] MF_SPRG1 = 32'h7c11_42a6;
  localparam logic [31:0] MF_SPRG2 = 32'h7c12_42a6;
  localparam logic [31:0] MF_SPRG3 = 32'h7c13_42a6;
  localparam logic [31:0] MF_SRR0  = 32'h7c1a_02a6;
  localparam logic [31:0] MF_SRR1  = 32'h7c1b_02a6;
  localparam logic [31:0] MF_DAR   = 32'h7c13_02a6;
  localparam logic [31:0] MF_DSISR = 32'h7c12_02a6;
  localparam logic [31:0] MT_SPRG0 = 32'h7c10_43a6;
  localparam logic [31:0] MT_SPRG1 = 32'h7c11_43a6;
  localparam logic [31:0] MT_SPRG2 = 32'h7c12_43a6;
  localparam logic [31:0] MT_SPRG3 = 32'h7c13_43a6;
  localparam logic [31:0] MT_SRR0  = 32'h7c1a_03a6;
  localparam logic [31:0] MT_SRR1  = 32'h7c1b_03a6;
  localparam logic [31:0] MT_DAR   = 32'h7c13_03a6;
  localparam logic [31:0] MT_DSISR = 32'h7c12_03a6;

  // Magic page at 0xffff9000, displacement of each field's low word
  localparam logic [31:0] PAGE_BASE = 32'hffff_9000;
  localparam logic [15:0] DISP_SPRG0 = 16'(PAGE_BASE + 32'd36);
  localparam logic [15:0] DISP_SPRG1 = 16'(PAGE_BASE + 32'd44);
  localparam logic [15:0] DISP_SPRG2 = 16'(PAGE_BASE + 32'd52);
  localparam logic [15:0] DISP_SPRG3 = 16'(PAGE_BASE + 32'd60);
  localparam logic [15:0] DISP_SRR0  = 16'(PAGE_BASE + 32'd68);
  localparam logic [15:0] DISP_SRR1  = 16'(PAGE_BASE + 32'd76);
  localparam logic [15:0] DISP_DAR   = 16'(PAGE_BASE + 32'd84);
  localparam logic [15:0] DISP_MSR   = 16'(PAGE_BASE + 32'd92);
  localparam logic [15:0] DISP_DSISR = 16'(PAGE_BASE + 32'd96);

  // Lowest register number that keeps mtsrin unpatched; only lower numbers are patched
  localparam logic [4:0] SEG_REG_LIMIT = 5'd30;

  typedef struct packed {
    logic [31:0] inst_address;
    logic [31:0] inst_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] new_word;
    logic [2:0]  patch_kind;
    logic [31:0] stub_address;
    logic        patching_ok;
  } out_item_t;

  // Decode result handed to the stub allocator
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  kind;
    logic        msr_br;
    logic        seg_br;
  } dec_t;

endpackage

`default_nettype wire

/* rtl/core/pir_decode.sv */
// Instruction decoder: classifies the word and builds load, store and nop rewrites.
// Branch forms are only flagged here; the stub allocator finishes them.
// Depends on pir_pkg.
`default_nettype none

module pir_decode
  import pir_pkg::*;
(
  input  wire logic [31:0] inst_word,
  output dec_t             dec
);

  logic [31:0] no_rt;
  logic [31:0] rt;
  logic [4:0]  rt_num;
  logic [4:0]  rb_num;

  assign no_rt  = inst_word & ~FLD_RT;
  assign rt     = inst_word & FLD_RT;
  assign rt_num = inst_word[25:21];
  assign rb_num = inst_word[15:11];

  always_comb begin
    dec.word   = inst_word;
    dec.kind   = KIND_NONE;
    dec.msr_br = 1'b0;
    dec.seg_br = 1'b0;
    unique case (no_rt)
      OP_MFMSR: begin dec.word = OP_LWZ | rt | {16'h0, DISP_MSR};   dec.kind = KIND_LOAD; end
      MF_SPRG0: begin dec.word = OP_LWZ | rt | {16'h0, DISP_SPRG0}; dec.kind = KIND_LOAD; end
      MF_SPRG1: begin dec.word = OP_LWZ | rt | {16'h0, DISP_SPRG1}; dec.kind = KIND_LOAD; end
      MF_SPRG2: begin dec.word = OP_LWZ | rt | {16'h0, DISP_SPRG2}; dec.kind = KIND_LOAD; end
      MF_SPRG3: begin dec.word = OP_LWZ | rt | {16'h0, DISP_SPRG3}; dec.kind = KIND_LOAD; end
      MF_SRR0:  begin dec.word = OP_LWZ | rt | {16'h0, DISP_SRR0};  dec.kind = KIND_LOAD; end
      MF_SRR1:  begin dec.word = OP_LWZ | rt | {16'h0, DISP_SRR1};  dec.kind = KIND_LOAD; end
      MF_DAR:   begin dec.word = OP_LWZ | rt | {16'h0, DISP_DAR};   dec.kind = KIND_LOAD; end
      MF_DSISR: begin dec.word = OP_LWZ | rt | {16'h0, DISP_DSISR}; dec.kind = KIND_LOAD; end
      MT_SPRG0: begin dec.word = OP_STW | rt | {16'h0, DISP_SPRG0}; dec.kind = KIND_STORE; end
      MT_SPRG1: begin dec.word = OP_STW | rt | {16'h0, DISP_SPRG1}; dec.kind = KIND_STORE; end
      MT_SPRG2: begin dec.word = OP_STW | rt | {16'h0, DISP_SPRG2}; dec.kind = KIND_STORE; end
      MT_SPRG3: begin dec.word = OP_STW | rt | {16'h0, DISP_SPRG3}; dec.kind = KIND_STORE; end
      MT_SRR0:  begin dec.word = OP_STW | rt | {16'h0, DISP_SRR0};  dec.kind = KIND_STORE; end
      MT_SRR1:  begin dec.word = OP_STW | rt | {16'h0, DISP_SRR1};  dec.kind = KIND_STORE; end
      MT_DAR:   begin dec.word = OP_STW | rt | {16'h0, DISP_DAR};   dec.kind = KIND_STORE; end
      MT_DSISR: begin dec.word = OP_STW | rt | {16'h0, DISP_DSISR}; dec.kind = KIND_STORE; end
      OP_TLBSYNC, OP_DCBA: begin
        dec.word = OP_NOP;
        dec.kind = KIND_NOP;
      end
      OP_MTMSR, OP_MTMSRD0, OP_MTMSRD1: begin
        dec.msr_br = 1'b1;
      end
      default: begin
        // mtsrin carries RB in the low field; r30 and r31 stay unpatched
        if ((no_rt & ~FLD_RB) == OP_MTSRIN && rt_num < SEG_REG_LIMIT &&
            rb_num < SEG_REG_LIMIT) begin
          dec.seg_br = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/pir_stub_alloc.sv */
// Stub allocator: bump arena fill counter, sticky range flag and branch build.
// Commits its state only when the transaction moves into the result register.
// Depends on pir_pkg.
`default_nettype none

module pir_stub_alloc
  import pir_pkg::*;
#(
  parameter int ARENA_BYTES = ARENA_BYTES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    advance,
  input  wire dec_t                    dec,
  input  wire logic [31:0]             inst_address,
  input  wire logic [31:0]             arena_base,
  input  wire logic [STUB_WORDS_W-1:0] msr_words,
  input  wire logic [STUB_WORDS_W-1:0] seg_words,
  output out_item_t                    res
);

  localparam int FILL_W  = $clog2(ARENA_BYTES + 1);
  localparam int BYTES_W = STUB_WORDS_W + 2;
  localparam int SUM_W   = ((FILL_W > BYTES_W) ? FILL_W : BYTES_W) + 1;

  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic                    ok_r, ok_nxt;
  logic [STUB_WORDS_W-1:0] words;
  logic [BYTES_W-1:0]      bytes;
  logic [SUM_W-1:0]        sum;
  logic                    need;
  logic                    nospc;
  logic [31:0]             stub;
  logic [31:0]             br_dist;
  logic                    bad;

  assign need    = dec.msr_br | dec.seg_br;
  assign words   = dec.msr_br ? msr_words : seg_words;
  assign bytes   = {words, 2'b00};
  assign sum     = SUM_W'(fill_r) + SUM_W'(bytes);
  assign nospc   = sum > SUM_W'(ARENA_BYTES);
  assign stub    = arena_base + 32'(fill_r);
  assign br_dist = stub - inst_address;
  // in range only when bits 31..25 are all equal
  assign bad     = (br_dist[31:25] != 7'h00) && (br_dist[31:25] != 7'h7f);

  always_comb begin
    res.new_word     = dec.word;
    res.patch_kind   = dec.kind;
    res.stub_address = 32'h0;
    res.patching_ok  = ok_r;
    fill_nxt         = fill_r;
    if (need) begin
      if (nospc) begin
        res.patch_kind = KIND_NOSPC;
      end else begin
        fill_nxt         = sum[FILL_W-1:0];
        res.stub_address = stub;
        if (bad) begin
          res.patch_kind  = KIND_RANGE;
          res.patching_ok = 1'b0;
        end else begin
          res.new_word   = OP_B | (br_dist & B_MASK);
          res.patch_kind = dec.msr_br ? KIND_MSR : KIND_SEG;
        end
      end
    end
    ok_nxt = res.patching_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ok_r   <= 1'b1;
    end else if (advance) begin
      fill_r <= fill_nxt;
      ok_r   <= ok_nxt;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(ARENA_BYTES))
    else $error("arena fill beyond arena size");

  a_ok_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !ok_r |=> !ok_r)
    else $error("patch failure flag cleared");

  a_nospc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.patch_kind == KIND_NOSPC) |=> $stable(fill_r))
    else $error("arena fill moved on refused stub");

  a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.patch_kind == KIND_RANGE) |=> !ok_r)
    else $error("range failure not recorded");
`endif

endmodule

`default_nettype wire

/* rtl/core/privileged_instruction_rewriter.sv */
// An accepted transaction passes the input register and then the result register before out_valid.
// Throughput: one instruction per cycle while out_stall is low; input register, decode and one
// arena add/compare, then the result register.
// in_stall follows out_stall only when both registers hold a transaction.
// Reset (rst_n low, synchronous): pipeline empty, arena fill 0, patch flag set,
// arena base 0, both stub lengths 16 words.
// Depends on pir_pkg, pir_decode and pir_stub_alloc.
`default_nettype none

module privileged_instruction_rewriter
  import pir_pkg::*;
#(
  parameter int ARENA_BYTES = ARENA_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  logic [31:0]             arena_base_r;
  logic [STUB_WORDS_W-1:0] msr_words_r;
  logic [STUB_WORDS_W-1:0] seg_words_r;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  logic      in_take;
  logic      out_load;
  dec_t      dec;
  out_item_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_base_r <= 32'h0;
      msr_words_r  <= STUB_WORDS_RST;
      seg_words_r  <= STUB_WORDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STUB_ARENA_BASE:   arena_base_r <= cfg_wdata[31:0];
        CFG_MSR_STUB_WORDS:    msr_words_r  <= cfg_wdata[STUB_WORDS_W-1:0];
        CFG_SEGREG_STUB_WORDS: seg_words_r  <= cfg_wdata[STUB_WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the input register whenever the result register can take it
  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  pir_decode u_decode (
    .inst_word (s1_data_r.inst_word),
    .dec       (dec)
  );

  pir_stub_alloc #(
    .ARENA_BYTES (ARENA_BYTES)
  ) u_alloc (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (out_load),
    .dec          (dec),
    .inst_address (s1_data_r.inst_address),
    .arena_base   (arena_base_r),
    .msr_words    (msr_words_r),
    .seg_words    (seg_words_r),
    .res          (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> s1_valid_r)
    else $error("held transaction dropped from input register");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
